>>> rtl/core/lprp_pkg.sv
// Shared types and constants for the length-prefixed record parser.
`default_nettype none

package lprp_pkg;

  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_KLEN    = 4'd1,
    PH_DLEN    = 4'd2,
    PH_EXPIRY  = 4'd3,
    PH_COLON   = 4'd4,
    PH_KEY     = 4'd5,
    PH_ARROW1  = 4'd6,
    PH_ARROW2  = 4'd7,
    PH_DATA    = 4'd8,
    PH_NEWLINE = 4'd9,
    PH_HALT    = 4'd10
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE = 3'd0,
    ERR_CHAR = 3'd1,
    ERR_LEN  = 3'd2,
    ERR_EXP  = 3'd3,
    ERR_END  = 3'd4
  } err_t;

  typedef enum logic [1:0] {
    KIND_FRAME  = 2'd0,
    KIND_KEY    = 2'd1,
    KIND_DATA   = 2'd2,
    KIND_REJECT = 2'd3
  } kind_t;

  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_COMMA   = 8'h2c;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_COLON   = 8'h3a;
  localparam logic [7:0] CH_DASH    = 8'h2d;
  localparam logic [7:0] CH_GT      = 8'h3e;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOW_A   = 8'h61;
  localparam logic [7:0] CH_LOW_F   = 8'h66;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_F    = 8'h46;

  localparam int EXPIRY_BITS = 64;
  localparam int LEN_OUT_BITS = 31;

endpackage

`default_nettype wire

>>> rtl/core/length_prefixed_record_parser_core.sv
// Byte-serial parser for +KEYLEN,DATALEN[@EXPIRY]:KEY->DATA records.
//
// Input channel: one byte per transfer (data_byte), or an end marker
// (end_of_input) that carries no byte. Output channel: one result per input
// transfer, classing the byte as framing, key or data and carrying the
// current record's lengths, expiry label, line number and status.
// A transfer happens when valid is high and stall is low at a clock edge.
//
// Throughput is one byte per clock unless the receiver stalls: the parse
// state advances in the cycle the byte is accepted, and the result lands in
// a single output register; out_valid rises in the cycle after the transfer.
// When the receiver stalls with a result pending, in_stall rises in the same
// cycle and the pending result and parse state are held until it drains.
//
// Synchronous reset returns the parser to the start of a record with all
// lengths, the expiry, the line counter and the error code cleared. Once an
// error is raised or the terminating empty line is seen, the parser halts:
// every later byte is answered as rejected until the next reset.
`default_nettype none

module length_prefixed_record_parser_core
  import lprp_pkg::*;
#(
  parameter int LENGTH_BITS   = 31,
  parameter int EXPIRY_DIGITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_input,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       byte_kind,
  output logic [7:0]       byte_value,
  output logic             record_done,
  output logic [30:0]      key_length,
  output logic [30:0]      data_length,
  output logic [63:0]      expiry_label,
  output logic             expiry_present,
  output logic             stream_done,
  output logic [2:0]       error_code,
  output logic [31:0]      record_number
);

  localparam int SUM_BITS = LENGTH_BITS + 4;

  // Parse state.
  phase_t                   phase, phase_next;
  logic [LENGTH_BITS-1:0]   num_acc, num_acc_next;
  logic [LENGTH_BITS-1:0]   remaining, remaining_next;
  logic [LENGTH_BITS-1:0]   key_len, key_len_next;
  logic [LENGTH_BITS-1:0]   data_len, data_len_next;
  logic [EXPIRY_BITS-1:0]   exp_acc, exp_acc_next;
  logic [4:0]               hex_count, hex_count_next;
  logic                     exp_seen, exp_seen_next;
  logic [31:0]              line_count, line_count_next;
  err_t                     err, err_next;
  logic                     finished, finished_next;

  // Per-byte decode.
  logic                     in_accept;
  logic                     is_digit;
  logic                     is_hex;
  logic [3:0]               hex_val;
  logic [SUM_BITS-1:0]      dec_sum;
  logic                     dec_overflow;
  logic [4:0]               hex_count_inc;
  kind_t                    kind;
  logic [7:0]               value;
  logic                     done;
  logic [31:0]              key_wide, data_wide;

  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  always_comb begin
    is_digit = 1'b0;
    is_hex   = 1'b1;
    hex_val  = data_byte[3:0];
    case (data_byte) inside
      [CH_ZERO:CH_NINE]: begin
        is_digit = 1'b1;
      end
      [CH_LOW_A:CH_LOW_F], [CH_UP_A:CH_UP_F]: begin
        hex_val = data_byte[3:0] + 4'd9;
      end
      default: begin
        is_hex = 1'b0;
      end
    endcase
  end

  // acc * 10 + digit as two shifted adds; the top four bits flag overflow.
  assign dec_sum = ({4'b0, num_acc} << 3) + ({4'b0, num_acc} << 1)
                 + SUM_BITS'(data_byte[3:0]);
  assign dec_overflow = |dec_sum[SUM_BITS-1:LENGTH_BITS];
  assign hex_count_inc = hex_count + 5'd1;

  always_comb begin
    phase_next      = phase;
    num_acc_next    = num_acc;
    remaining_next  = remaining;
    key_len_next    = key_len;
    data_len_next   = data_len;
    exp_acc_next    = exp_acc;
    hex_count_next  = hex_count;
    exp_seen_next   = exp_seen;
    line_count_next = line_count;
    err_next        = err;
    finished_next   = finished;
    kind            = KIND_FRAME;
    value           = end_of_input ? 8'd0 : data_byte;
    done            = 1'b0;

    if (phase == PH_HALT) begin
      kind  = KIND_REJECT;
      value = 8'd0;
    end else begin
      if (phase == PH_START && line_count != '1) begin
        line_count_next = line_count + 32'd1;
      end
      if (end_of_input) begin
        err_next   = ERR_END;
        phase_next = PH_HALT;
      end else begin
        case (phase)
          PH_START: begin
            if (data_byte == CH_PLUS) begin
              num_acc_next   = '0;
              key_len_next   = '0;
              data_len_next  = '0;
              exp_acc_next   = '0;
              hex_count_next = '0;
              exp_seen_next  = 1'b0;
              phase_next     = PH_KLEN;
            end else if (data_byte == CH_NEWLINE) begin
              finished_next = 1'b1;
              phase_next    = PH_HALT;
            end else begin
              err_next   = ERR_CHAR;
              phase_next = PH_HALT;
            end
          end
          PH_KLEN, PH_DLEN: begin
            if (is_digit) begin
              if (dec_overflow) begin
                err_next   = ERR_LEN;
                phase_next = PH_HALT;
              end else begin
                num_acc_next = dec_sum[LENGTH_BITS-1:0];
              end
            end else if (phase == PH_KLEN) begin
              if (data_byte == CH_COMMA) begin
                key_len_next = num_acc;
                num_acc_next = '0;
                phase_next   = PH_DLEN;
              end else begin
                err_next   = ERR_CHAR;
                phase_next = PH_HALT;
              end
            end else if (data_byte == CH_AT) begin
              data_len_next = num_acc;
              exp_seen_next = 1'b1;
              phase_next    = PH_EXPIRY;
            end else if (data_byte == CH_COLON) begin
              data_len_next  = num_acc;
              remaining_next = key_len;
              phase_next     = (key_len != '0) ? PH_KEY : PH_ARROW1;
            end else begin
              err_next   = ERR_CHAR;
              phase_next = PH_HALT;
            end
          end
          PH_EXPIRY: begin
            if (!is_hex) begin
              err_next   = ERR_EXP;
              phase_next = PH_HALT;
            end else begin
              exp_acc_next   = {exp_acc[EXPIRY_BITS-5:0], hex_val};
              hex_count_next = hex_count_inc;
              if (hex_count_inc >= 5'(EXPIRY_DIGITS)) begin
                phase_next = PH_COLON;
              end
            end
          end
          PH_COLON: begin
            if (data_byte == CH_COLON) begin
              remaining_next = key_len;
              phase_next     = (key_len != '0) ? PH_KEY : PH_ARROW1;
            end else begin
              err_next   = ERR_CHAR;
              phase_next = PH_HALT;
            end
          end
          PH_KEY: begin
            kind           = KIND_KEY;
            remaining_next = remaining - LENGTH_BITS'(1);
            if (remaining_next == '0) begin
              phase_next = PH_ARROW1;
            end
          end
          PH_ARROW1: begin
            if (data_byte == CH_DASH) begin
              phase_next = PH_ARROW2;
            end else begin
              err_next   = ERR_CHAR;
              phase_next = PH_HALT;
            end
          end
          PH_ARROW2: begin
            if (data_byte == CH_GT) begin
              remaining_next = data_len;
              phase_next     = (data_len != '0) ? PH_DATA : PH_NEWLINE;
            end else begin
              err_next   = ERR_CHAR;
              phase_next = PH_HALT;
            end
          end
          PH_DATA: begin
            kind           = KIND_DATA;
            remaining_next = remaining - LENGTH_BITS'(1);
            if (remaining_next == '0) begin
              phase_next = PH_NEWLINE;
            end
          end
          PH_NEWLINE: begin
            if (data_byte == CH_NEWLINE) begin
              done       = 1'b1;
              phase_next = PH_START;
            end else begin
              err_next   = ERR_CHAR;
              phase_next = PH_HALT;
            end
          end
          default: begin
            err_next   = ERR_CHAR;
            phase_next = PH_HALT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_START;
      num_acc    <= '0;
      remaining  <= '0;
      key_len    <= '0;
      data_len   <= '0;
      exp_acc    <= '0;
      hex_count  <= '0;
      exp_seen   <= 1'b0;
      line_count <= '0;
      err        <= ERR_NONE;
      finished   <= 1'b0;
    end else if (in_accept) begin
      phase      <= phase_next;
      num_acc    <= num_acc_next;
      remaining  <= remaining_next;
      key_len    <= key_len_next;
      data_len   <= data_len_next;
      exp_acc    <= exp_acc_next;
      hex_count  <= hex_count_next;
      exp_seen   <= exp_seen_next;
      line_count <= line_count_next;
      err        <= err_next;
      finished   <= finished_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Lengths are reported at the fixed 31-bit field width.
  assign key_wide  = 32'(key_len_next);
  assign data_wide = 32'(data_len_next);

  always_ff @(posedge clk) begin
    if (in_accept) begin
      byte_kind      <= kind;
      byte_value     <= value;
      record_done    <= done;
      key_length     <= key_wide[LEN_OUT_BITS-1:0];
      data_length    <= data_wide[LEN_OUT_BITS-1:0];
      expiry_label   <= exp_seen_next ? exp_acc_next : '0;
      expiry_present <= exp_seen_next;
      stream_done    <= finished_next;
      error_code     <= err_next;
      record_number  <= line_count_next;
    end
  end

  // A halted parser never resumes without reset.
  assert property (@(posedge clk) disable iff (rst)
    phase == PH_HALT |=> phase == PH_HALT)
    else $error("parser left the halted phase");

  // A latched error always goes with the halted phase.
  assert property (@(posedge clk) disable iff (rst)
    err != ERR_NONE |-> phase == PH_HALT)
    else $error("error latched while still parsing");

  // A finished stream is halted and carries no error.
  assert property (@(posedge clk) disable iff (rst)
    finished |-> (phase == PH_HALT && err == ERR_NONE))
    else $error("stream done with error or active phase");

  // Key and data phases are entered only with bytes left to count.
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_KEY || phase == PH_DATA) |-> remaining != '0)
    else $error("payload phase with zero bytes remaining");

endmodule

`default_nettype wire
